// ===== rtl/pws_pkg.sv =====
package pws_pkg;

  localparam int Q_ONE       = 65536;
  localparam int GLOW_BASE   = 38011;   // 0.58 in Q16
  localparam int GLOW_SWING  = 27525;   // 0.42 in Q16
  localparam int BYTE_SCALE  = 262;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 26;

  typedef enum logic [CFG_IW-1:0] {
    CFG_STRAND_COUNT   = 3'd0,
    CFG_GLOW_FREQ      = 3'd1,
    CFG_DRIFT_OFFSET   = 3'd2,
    CFG_SPIN_OFFSET    = 3'd3,
    CFG_HALF_WIDTH     = 3'd4,
    CFG_INV_HALF_WIDTH = 3'd5,
    CFG_GLOW_PHASE     = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_SHADE = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic signed [23:0] pixel_a;
    logic signed [23:0] pixel_b;
    logic        [23:0] inv_edge;
    logic        [16:0] coverage;
    logic               colour_family;
    logic        [4:0]  colour_index;
    logic        [16:0] red_in;
    logic        [16:0] green_in;
    logic        [16:0] blue_in;
  } pws_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pws_out_t;

endpackage

// ===== rtl/pws_isqrt.sv =====
// Floor square root, three register stages: six, six and five result bits.
module pws_isqrt (
  input  logic        clk,
  input  logic [32:0] x_in,
  output logic [16:0] root_out
);

  logic [33:0] rem1_r, root1_r, rem2_r, root2_r, root3_r;
  logic [67:0] st1_nxt, st2_nxt, st3_nxt;

  function automatic logic [67:0] sqrt_steps(input logic [33:0] x_i, input logic [33:0] r_i,
                                             input int first, input int last);
    logic [33:0] x;
    logic [33:0] r;
    logic [33:0] b;
    x = x_i;
    r = r_i;
    for (int i = first; i <= last; i++) begin
      b = 34'(1) << (32 - 2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return {x, r};
  endfunction

  always_comb begin
    st1_nxt = sqrt_steps({1'b0, x_in}, 34'd0, 0, 5);
    st2_nxt = sqrt_steps(rem1_r, root1_r, 6, 11);
    st3_nxt = sqrt_steps(rem2_r, root2_r, 12, 16);
  end

  always_ff @(posedge clk) begin
    {rem1_r, root1_r} <= st1_nxt;
    {rem2_r, root2_r} <= st2_nxt;
    root3_r           <= st3_nxt[33:0];
  end

  assign root_out = root3_r[16:0];

endmodule

// ===== rtl/plait_weave_pixel_shader.sv =====
// Channel   Ports                            Handshake
// input     start, busy, in_data             transfer when start && !busy
// result    out_valid, out_data              one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data      write when cfg_we
//
// Twelve-stage pipeline: a shade item gives its result from the stage 12 register;
// a load item writes its colour entry from the stage 5 registers and gives no result.
// One item per cycle, busy stays low; the depth is set by the three-stage square
// root and the multiplier chain behind the colour table read.
// rst_n (synchronous) clears valid bits and restores register defaults.
// The receiver cannot stall, so results leave on their fixed schedule.
module plait_weave_pixel_shader
  import pws_pkg::*;
#(
  parameter int MAX_STRANDS = 32,
  parameter int SINE_STEPS  = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pws_in_t           in_data,
  output logic              out_valid,
  output pws_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // SINE_STEPS is taken as a power of two
  localparam int AW = $clog2(MAX_STRANDS);
  localparam int SW = $clog2(SINE_STEPS);

  // ---------------- sine table ----------------
  logic signed [17:0] sine_rom [SINE_STEPS];

  for (genvar gi = 0; gi < SINE_STEPS; gi++) begin : g_sine
    localparam longint J    = 4 * gi;
    localparam longint QUAD = J / SINE_STEPS;
    localparam longint REM  = J % SINE_STEPS;
    localparam longint A    = HALF_PI_Q30 * REM / SINE_STEPS;
    localparam longint BASE = (QUAD % 2 == 1) ? 1 : 2;
    localparam longint T0   = (QUAD % 2 == 1) ? 64'sd1073741824 : A;
    localparam longint T1   = (((T0 * A) >>> 30) * A >>> 30) / ((BASE) * (BASE + 1));
    localparam longint T2   = (((T1 * A) >>> 30) * A >>> 30) / ((BASE + 2) * (BASE + 3));
    localparam longint T3   = (((T2 * A) >>> 30) * A >>> 30) / ((BASE + 4) * (BASE + 5));
    localparam longint T4   = (((T3 * A) >>> 30) * A >>> 30) / ((BASE + 6) * (BASE + 7));
    localparam longint T5   = (((T4 * A) >>> 30) * A >>> 30) / ((BASE + 8) * (BASE + 9));
    localparam longint T6   = (((T5 * A) >>> 30) * A >>> 30) / ((BASE + 10) * (BASE + 11));
    localparam longint T7   = (((T6 * A) >>> 30) * A >>> 30) / ((BASE + 12) * (BASE + 13));
    localparam longint T8   = (((T7 * A) >>> 30) * A >>> 30) / ((BASE + 14) * (BASE + 15));
    localparam longint T9   = (((T8 * A) >>> 30) * A >>> 30) / ((BASE + 16) * (BASE + 17));
    localparam longint T10  = (((T9 * A) >>> 30) * A >>> 30) / ((BASE + 18) * (BASE + 19));
    localparam longint T11  = (((T10 * A) >>> 30) * A >>> 30) / ((BASE + 20) * (BASE + 21));
    localparam longint T12  = (((T11 * A) >>> 30) * A >>> 30) / ((BASE + 22) * (BASE + 23));
    localparam longint SUM  = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
                              - T11 + T12;
    localparam longint SPOS = (SUM < 0) ? 0 : SUM;
    localparam longint SRND = (SPOS + 8192) >>> 14;
    localparam longint SVAL = (QUAD >= 2) ? -SRND : SRND;
    assign sine_rom[gi] = 18'(SVAL);
  end

  // ---------------- configuration ----------------
  logic        [5:0]  strand_count_r;
  logic        [24:0] glow_freq_r;
  logic signed [23:0] drift_offset_r;
  logic signed [23:0] spin_offset_r;
  logic        [15:0] half_width_r;
  logic        [19:0] inv_half_width_r;
  logic        [25:0] glow_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strand_count_r   <= 6'd10;
      glow_freq_r      <= 25'd20107200;
      drift_offset_r   <= '0;
      spin_offset_r    <= '0;
      half_width_r     <= 16'd15728;
      inv_half_width_r <= 20'd272800;
      glow_phase_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STRAND_COUNT:   strand_count_r   <= cfg_data[5:0];
        CFG_GLOW_FREQ:      glow_freq_r      <= cfg_data[24:0];
        CFG_DRIFT_OFFSET:   drift_offset_r   <= cfg_data[23:0];
        CFG_SPIN_OFFSET:    spin_offset_r    <= cfg_data[23:0];
        CFG_HALF_WIDTH:     half_width_r     <= cfg_data[15:0];
        CFG_INV_HALF_WIDTH: inv_half_width_r <= cfg_data[19:0];
        CFG_GLOW_PHASE:     glow_phase_r     <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  // clamped strand count
  logic [6:0] n_strands;
  always_comb begin
    if (strand_count_r == 6'd0)                      n_strands = 7'd1;
    else if ({1'b0, strand_count_r} > 7'(MAX_STRANDS)) n_strands = 7'(MAX_STRANDS);
    else                                             n_strands = {1'b0, strand_count_r};
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  function automatic logic [9:0] mod_steps(input logic [9:0] rem_i, input logic [6:0] n,
                                           input int hi, input int lo);
    logic [9:0]  rem;
    logic [16:0] nk;
    rem = rem_i;
    for (int k = hi; k >= lo; k--) begin
      nk = 17'(n) << k;
      if ({7'b0, rem} >= nk) rem = rem - nk[9:0];
    end
    return rem;
  endfunction

  // ---------------- stage 1: strand coordinates ----------------
  logic               vld1_r, act1_r;
  logic signed [25:0] u1_r, v1_r;
  logic        [23:0] inv_e1_r;
  logic        [16:0] cov1_r;
  logic               fam1_r;
  logic        [4:0]  cidx1_r;
  logic        [50:0] rgb1_r;
  logic signed [24:0] a_nxt, b_nxt;

  assign a_nxt = {in_data.pixel_a[23], in_data.pixel_a} + {drift_offset_r[23], drift_offset_r};
  assign b_nxt = {in_data.pixel_b[23], in_data.pixel_b} + {spin_offset_r[23], spin_offset_r};

  always_ff @(posedge clk) begin
    u1_r     <= {a_nxt[24], a_nxt} + {b_nxt[24], b_nxt};
    v1_r     <= {a_nxt[24], a_nxt} - {b_nxt[24], b_nxt};
    act1_r   <= in_data.action;
    inv_e1_r <= in_data.inv_edge;
    cov1_r   <= in_data.coverage;
    fam1_r   <= in_data.colour_family;
    cidx1_r  <= in_data.colour_index;
    rgb1_r   <= {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  // ---------------- stage 2: distances and products ----------------
  logic        [15:0] du_nxt, dv_nxt;
  logic signed [17:0] diffa_nxt, diffb_nxt;
  logic        [35:0] qpa_nxt, qpb_nxt;
  logic        [9:0]  iu_nxt, iv_nxt;

  logic               vld2_r, act2_r, fam2_r;
  logic        [16:0] cov2_r;
  logic        [4:0]  cidx2_r;
  logic        [50:0] rgb2_r;
  logic        [40:0] epa2_r, epb2_r;
  logic               posa2_r, posb2_r;
  logic        [19:0] qa2_r, qb2_r;
  logic signed [51:0] gpa2_r, gpb2_r;
  logic               par2_r, nega2_r, negb2_r;
  logic        [9:0]  maga2_r, magb2_r;

  always_comb begin
    du_nxt    = u1_r[15] ? {1'b0, u1_r[14:0]} : 16'd32768 - u1_r[15:0];
    dv_nxt    = v1_r[15] ? {1'b0, v1_r[14:0]} : 16'd32768 - v1_r[15:0];
    diffa_nxt = $signed({2'b0, half_width_r}) - $signed({2'b0, du_nxt});
    diffb_nxt = $signed({2'b0, half_width_r}) - $signed({2'b0, dv_nxt});
    qpa_nxt   = du_nxt * inv_half_width_r;
    qpb_nxt   = dv_nxt * inv_half_width_r;
    iu_nxt    = u1_r[25:16];
    iv_nxt    = v1_r[25:16];
  end

  always_ff @(posedge clk) begin
    act2_r  <= act1_r;
    fam2_r  <= fam1_r;
    cov2_r  <= cov1_r;
    cidx2_r <= cidx1_r;
    rgb2_r  <= rgb1_r;
    epa2_r  <= diffa_nxt[16:0] * inv_e1_r;
    epb2_r  <= diffb_nxt[16:0] * inv_e1_r;
    posa2_r <= !diffa_nxt[17] && (diffa_nxt != 18'sd0);
    posb2_r <= !diffb_nxt[17] && (diffb_nxt != 18'sd0);
    qa2_r   <= qpa_nxt[35:16];
    qb2_r   <= qpb_nxt[35:16];
    gpa2_r  <= v1_r * $signed({1'b0, glow_freq_r});
    gpb2_r  <= u1_r * $signed({1'b0, glow_freq_r});
    par2_r  <= iu_nxt[0] ^ iv_nxt[0];
    nega2_r <= iu_nxt[9];
    negb2_r <= iv_nxt[9];
    maga2_r <= iu_nxt[9] ? 10'd0 - iu_nxt : iu_nxt;
    magb2_r <= iv_nxt[9] ? 10'd0 - iv_nxt : iv_nxt;
  end

  // ---------------- stage 3: edge weight, shade argument, glow index ----------------
  logic        [16:0] ta_nxt, tb_nxt, xa_nxt, xb_nxt;
  logic        [39:0] qqa_nxt, qqb_nxt;
  logic signed [52:0] pa_nxt, pb_nxt, pma_nxt, pmb_nxt;
  logic        [20:0] ma_nxt, mb_nxt, ia_nxt, ib_nxt;

  logic               vld3_r, act3_r, fam3_r;
  logic        [16:0] cov3_r;
  logic        [4:0]  cidx3_r;
  logic        [50:0] rgb3_r;
  logic        [16:0] ta3_r, tb3_r, xa3_r, xb3_r;
  logic        [SW-1:0] ia3_r, ib3_r;
  logic               par3_r, nega3_r, negb3_r;
  logic        [9:0]  rema3_r, remb3_r;

  always_comb begin
    if (!posa2_r)                    ta_nxt = '0;
    else if (epa2_r[40:16] > 25'd65536) ta_nxt = 17'd65536;
    else                             ta_nxt = epa2_r[32:16];
    if (!posb2_r)                    tb_nxt = '0;
    else if (epb2_r[40:16] > 25'd65536) tb_nxt = 17'd65536;
    else                             tb_nxt = epb2_r[32:16];
    qqa_nxt = qa2_r * qa2_r;
    qqb_nxt = qb2_r * qb2_r;
    xa_nxt  = (qqa_nxt[39:16] >= 24'd65536) ? 17'd0 : 17'(24'd65536 - qqa_nxt[39:16]);
    xb_nxt  = (qqb_nxt[39:16] >= 24'd65536) ? 17'd0 : 17'(24'd65536 - qqb_nxt[39:16]);
    // ribbon A glows along v with negative phase, ribbon B along u with positive
    pa_nxt  = {gpa2_r[51], gpa2_r} - $signed({11'b0, glow_phase_r, 16'b0});
    pb_nxt  = {gpb2_r[51], gpb2_r} + $signed({11'b0, glow_phase_r, 16'b0});
    pma_nxt = pa_nxt[52] ? -pa_nxt : pa_nxt;
    pmb_nxt = pb_nxt[52] ? -pb_nxt : pb_nxt;
    ma_nxt  = pma_nxt[52:32];
    mb_nxt  = pmb_nxt[52:32];
    // truncate toward zero, then low bits give the floor modulo
    ia_nxt  = pa_nxt[52] ? 21'd0 - ma_nxt : ma_nxt;
    ib_nxt  = pb_nxt[52] ? 21'd0 - mb_nxt : mb_nxt;
  end

  always_ff @(posedge clk) begin
    act3_r  <= act2_r;
    fam3_r  <= fam2_r;
    cov3_r  <= cov2_r;
    cidx3_r <= cidx2_r;
    rgb3_r  <= rgb2_r;
    ta3_r   <= ta_nxt;
    tb3_r   <= tb_nxt;
    xa3_r   <= xa_nxt;
    xb3_r   <= xb_nxt;
    ia3_r   <= ia_nxt[SW-1:0];
    ib3_r   <= ib_nxt[SW-1:0];
    par3_r  <= par2_r;
    nega3_r <= nega2_r;
    negb3_r <= negb2_r;
    rema3_r <= mod_steps(maga2_r, n_strands, 9, 5);
    remb3_r <= mod_steps(magb2_r, n_strands, 9, 5);
  end

  // ---------------- stages 4..6: square root ----------------
  logic [16:0] sa6, sb6;

  pws_isqrt u_sqrt_a (.clk(clk), .x_in({xa3_r, 16'b0}), .root_out(sa6));
  pws_isqrt u_sqrt_b (.clk(clk), .x_in({xb3_r, 16'b0}), .root_out(sb6));

  // ---------------- stage 4: glow ----------------
  logic signed [33:0] gpra_nxt, gprb_nxt, gsa_nxt, gsb_nxt;

  logic               vld4_r, act4_r, fam4_r;
  logic        [16:0] cov4_r;
  logic        [4:0]  cidx4_r;
  logic        [50:0] rgb4_r;
  logic        [16:0] ta4_r, tb4_r, ga4_r, gb4_r;
  logic               par4_r, zero4_r, nega4_r, negb4_r;
  logic        [9:0]  rema4_r, remb4_r;

  always_comb begin
    gpra_nxt = sine_rom[ia3_r] * 34'sd27525;
    gprb_nxt = sine_rom[ib3_r] * 34'sd27525;
    gsa_nxt  = 34'(GLOW_BASE) + (gpra_nxt >>> 16);
    gsb_nxt  = 34'(GLOW_BASE) + (gprb_nxt >>> 16);
  end

  always_ff @(posedge clk) begin
    act4_r  <= act3_r;
    fam4_r  <= fam3_r;
    cov4_r  <= cov3_r;
    cidx4_r <= cidx3_r;
    rgb4_r  <= rgb3_r;
    ta4_r   <= ta3_r;
    tb4_r   <= tb3_r;
    ga4_r   <= gsa_nxt[16:0];
    gb4_r   <= gsb_nxt[16:0];
    par4_r  <= par3_r;
    zero4_r <= (ta3_r == 17'd0) && (tb3_r == 17'd0);
    nega4_r <= nega3_r;
    negb4_r <= negb3_r;
    rema4_r <= mod_steps(rema3_r, n_strands, 4, 0);
    remb4_r <= mod_steps(remb3_r, n_strands, 4, 0);
  end

  // ---------------- stage 5: colour index ----------------
  logic               vld5_r, act5_r, fam5_r;
  logic        [16:0] cov5_r;
  logic        [4:0]  cidx5_r;
  logic        [50:0] rgb5_r;
  logic        [16:0] ta5_r, tb5_r, ga5_r, gb5_r;
  logic               par5_r, zero5_r;
  logic        [AW-1:0] addra5_r, addrb5_r;
  logic        [9:0]  fixa_nxt, fixb_nxt;

  always_comb begin
    fixa_nxt = (nega4_r && rema4_r != 10'd0) ? {3'b0, n_strands} - rema4_r : rema4_r;
    fixb_nxt = (negb4_r && remb4_r != 10'd0) ? {3'b0, n_strands} - remb4_r : remb4_r;
  end

  always_ff @(posedge clk) begin
    act5_r   <= act4_r;
    fam5_r   <= fam4_r;
    cov5_r   <= cov4_r;
    cidx5_r  <= cidx4_r;
    rgb5_r   <= rgb4_r;
    ta5_r    <= ta4_r;
    tb5_r    <= tb4_r;
    ga5_r    <= ga4_r;
    gb5_r    <= gb4_r;
    par5_r   <= par4_r;
    zero5_r  <= zero4_r;
    addra5_r <= fixa_nxt[AW-1:0];
    addrb5_r <= fixb_nxt[AW-1:0];
  end

  // ---------------- stage 6: colour tables ----------------
  logic [50:0] mem_a [MAX_STRANDS];
  logic [50:0] mem_b [MAX_STRANDS];
  logic        load_we;

  // loads write here so that reads and writes keep transfer order
  assign load_we = vld5_r && (act5_r == ACT_LOAD) && ({2'b0, cidx5_r} < 7'(MAX_STRANDS));

  logic               vld6_r, zero6_r, par6_r;
  logic        [16:0] cov6_r, ta6_r, tb6_r, ga6_r, gb6_r;
  logic        [50:0] cola6_r, colb6_r;

  always_ff @(posedge clk) begin
    if (load_we && !fam5_r) mem_a[AW'(cidx5_r)] <= rgb5_r;
    if (load_we && fam5_r)  mem_b[AW'(cidx5_r)] <= rgb5_r;
    cola6_r <= mem_a[addra5_r];
    colb6_r <= mem_b[addrb5_r];
    cov6_r  <= cov5_r;
    ta6_r   <= ta5_r;
    tb6_r   <= tb5_r;
    ga6_r   <= ga5_r;
    gb6_r   <= gb5_r;
    par6_r  <= par5_r;
    zero6_r <= zero5_r;
  end

  // ---------------- stage 7: edge times shade ----------------
  logic        [33:0] tsa_nxt, tsb_nxt;
  logic               vld7_r, zero7_r, par7_r;
  logic        [16:0] cov7_r, ta7_r, tb7_r, ga7_r, gb7_r, tsa7_r, tsb7_r;
  logic        [50:0] cola7_r, colb7_r;

  assign tsa_nxt = ta6_r * sa6;
  assign tsb_nxt = tb6_r * sb6;

  always_ff @(posedge clk) begin
    tsa7_r  <= tsa_nxt[32:16];
    tsb7_r  <= tsb_nxt[32:16];
    cov7_r  <= cov6_r;
    ta7_r   <= ta6_r;
    tb7_r   <= tb6_r;
    ga7_r   <= ga6_r;
    gb7_r   <= gb6_r;
    par7_r  <= par6_r;
    zero7_r <= zero6_r;
    cola7_r <= cola6_r;
    colb7_r <= colb6_r;
  end

  // ---------------- stage 8: glow weight ----------------
  logic        [33:0] wa_nxt, wb_nxt;
  logic               vld8_r, zero8_r, par8_r;
  logic        [16:0] cov8_r, ta8_r, tb8_r, wa8_r, wb8_r;
  logic        [50:0] cola8_r, colb8_r;

  assign wa_nxt = tsa7_r * ga7_r;
  assign wb_nxt = tsb7_r * gb7_r;

  always_ff @(posedge clk) begin
    wa8_r   <= wa_nxt[32:16];
    wb8_r   <= wb_nxt[32:16];
    cov8_r  <= cov7_r;
    ta8_r   <= ta7_r;
    tb8_r   <= tb7_r;
    par8_r  <= par7_r;
    zero8_r <= zero7_r;
    cola8_r <= cola7_r;
    colb8_r <= colb7_r;
  end

  // ---------------- stage 9: over/under ----------------
  logic        [33:0] ova_nxt, ovb_nxt;
  logic               vld9_r, zero9_r;
  logic        [16:0] cov9_r, wa9_r, wb9_r;
  logic        [50:0] cola9_r, colb9_r;

  // even parity: ribbon A on top, B hidden by A's edge
  assign ova_nxt = wa8_r * (17'd65536 - tb8_r);
  assign ovb_nxt = wb8_r * (17'd65536 - ta8_r);

  always_ff @(posedge clk) begin
    wa9_r   <= par8_r ? ova_nxt[32:16] : wa8_r;
    wb9_r   <= par8_r ? wb8_r : ovb_nxt[32:16];
    cov9_r  <= cov8_r;
    zero9_r <= zero8_r;
    cola9_r <= cola8_r;
    colb9_r <= colb8_r;
  end

  // ---------------- stage 10: blend ----------------
  logic [34:0] mix_nxt [3];
  logic        vld10_r, zero10_r;
  logic [16:0] cov10_r;
  logic [18:0] ch10_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix_nxt[c] = 35'(cola9_r[50 - 17 * c -: 17] * wa9_r)
                 + 35'(colb9_r[50 - 17 * c -: 17] * wb9_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) ch10_r[c] <= mix_nxt[c][34:16];
    cov10_r  <= cov9_r;
    zero10_r <= zero9_r;
  end

  // ---------------- stage 11: coverage ----------------
  logic [35:0] cv_nxt [3];
  logic        vld11_r, zero11_r;
  logic [19:0] ch11_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) cv_nxt[c] = ch10_r[c] * cov10_r;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) ch11_r[c] <= cv_nxt[c][35:16];
    zero11_r <= zero10_r;
  end

  // ---------------- stage 12: byte scale and saturate ----------------
  logic [28:0] sc_nxt [3];
  logic [7:0]  byte_nxt [3];
  logic        out_valid_r;
  pws_out_t    out_data_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc_nxt[c] = ch11_r[c] * 9'd262;
      if (zero11_r)                      byte_nxt[c] = 8'd0;
      else if (sc_nxt[c][28:16] > 13'd255) byte_nxt[c] = 8'd255;
      else                               byte_nxt[c] = sc_nxt[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= '{red_out: byte_nxt[0], green_out: byte_nxt[1], blue_out: byte_nxt[2]};
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      vld5_r      <= 1'b0;
      vld6_r      <= 1'b0;
      vld7_r      <= 1'b0;
      vld8_r      <= 1'b0;
      vld9_r      <= 1'b0;
      vld10_r     <= 1'b0;
      vld11_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= accept;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      vld5_r      <= vld4_r;
      // from here on only shade items travel
      vld6_r      <= vld5_r && (act5_r == ACT_SHADE);
      vld7_r      <= vld6_r;
      vld8_r      <= vld7_r;
      vld9_r      <= vld8_r;
      vld10_r     <= vld9_r;
      vld11_r     <= vld10_r;
      out_valid_r <= vld11_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_out_from_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && in_data.action == ACT_SHADE, 12))
    else $error("result without a shade transfer");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && act5_r == ACT_SHADE) |->
      ({{(7-AW){1'b0}}, addra5_r} < n_strands && {{(7-AW){1'b0}}, addrb5_r} < n_strands))
    else $error("colour index out of range");

  a_zero_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (vld6_r && zero6_r) |-> ##6 (out_valid && out_data == '0))
    else $error("zero edges gave nonzero colour");

endmodule
